// ----- design/murmur64_stream_hash_core_defines.svh -----
// assertion macros shared by the hash core
`ifndef MURMUR64_STREAM_HASH_CORE_DEFINES_SVH
`define MURMUR64_STREAM_HASH_CORE_DEFINES_SVH

// same-cycle implication, sampled on clk, off during rst
`define MMH_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("mmh check failed");

// next-cycle implication, sampled on clk, off during rst
`define MMH_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("mmh check failed");

`endif

// ----- design/mmh_pkg.sv -----
// types, constants and helper functions of the murmur64 hash core
package mmh_pkg;

  localparam logic [63:0] MUL_CONST  = 64'hc6a4a7935bd1e995;
  localparam int          SHIFT_R    = 47;
  localparam logic [3:0]  FULL_BYTES = 4'd8;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam int TDATA_W = 104;

  typedef enum logic [1:0] {
    OP_FULL,
    OP_TAIL,
    OP_NONE
  } op_kind_t;

  typedef struct packed {
    logic [63:0] data;
    logic [31:0] length;
    op_kind_t    kind;
    logic        first;
    logic        last;
  } op_t;

  typedef struct packed {
    logic busy;
    logic emit;
    logic mul_busy;
  } bk_stat_t;

  function automatic logic [63:0] xorshift(input logic [63:0] x);
    return x ^ (x >> SHIFT_R);
  endfunction

  function automatic logic [63:0] tail_mask(input logic [3:0] nb);
    logic [63:0] m;
    for (int i = 0; i < 8; i++) begin
      m[i*8 +: 8] = (4'(i) < nb) ? 8'hFF : 8'h00;
    end
    return m;
  endfunction

endpackage

// ----- design/mmh_front.sv -----
// front end: classifies each incoming request into a mixing operation
module mmh_front (
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [63:0]      data_word,
  input  logic [3:0]       word_bytes,
  input  logic             first,
  input  logic             last,
  input  logic [31:0]      message_length,
  output logic             push,
  output mmh_pkg::op_t     push_op,
  input  logic             q_full
);
  import mmh_pkg::*;

  logic [3:0] nbytes;

  assign in_ready = !q_full;
  assign push     = in_valid && !q_full;

  // saturate byte count at a full word
  assign nbytes = (word_bytes > FULL_BYTES) ? FULL_BYTES : word_bytes;

  always_comb begin
    push_op.length = message_length;
    push_op.first  = first;
    push_op.last   = last;
    push_op.data   = data_word;
    if (!last || nbytes == FULL_BYTES) begin
      push_op.kind = OP_FULL;
    end else if (nbytes == 4'd0) begin
      push_op.kind = OP_NONE;
    end else begin
      push_op.kind = OP_TAIL;
      push_op.data = data_word & tail_mask(nbytes);
    end
  end

endmodule

// ----- design/mmh_queue.sv -----
// short request queue between front end and back end
module mmh_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  mmh_pkg::op_t     push_op,
  output logic             full,
  output logic             q_valid,
  output mmh_pkg::op_t     q_op,
  input  logic             pop
);
  import mmh_pkg::*;

  op_t               entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  assign full    = (count == QCNT_W'(QUEUE_DEPTH));
  assign q_valid = (count != '0);
  assign q_op    = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_op;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ----- design/mmh_mul.sv -----
// multi-cycle multiplier by the hash constant, one 32x32 partial product a cycle
module mmh_mul (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] operand,
  output logic [63:0] product,
  output logic        done,
  output logic        busy
);
  import mmh_pkg::*;

  typedef enum logic [1:0] {
    PH_LL,
    PH_LH,
    PH_HL
  } phase_t;

  localparam logic [31:0] M_LO = MUL_CONST[31:0];
  localparam logic [31:0] M_HI = MUL_CONST[63:32];

  logic [63:0] a;
  phase_t      phase;
  logic [31:0] mul_x;
  logic [31:0] mul_y;
  logic [63:0] pp;

  always_comb begin
    mul_x = a[31:0];
    mul_y = M_LO;
    case (phase)
      PH_LH:   mul_y = M_HI;
      PH_HL:   mul_x = a[63:32];
      default: ;
    endcase
    pp = mul_x * mul_y;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      phase <= PH_LL;
    end else begin
      // pulse once the last partial product has been added
      done <= busy && !start && (phase == PH_HL);
      if (start) begin
        a     <= operand;
        busy  <= 1'b1;
        phase <= PH_LL;
      end else if (busy) begin
        unique case (phase)
          PH_LL: begin
            product <= pp;
            phase   <= PH_LH;
          end
          PH_LH: begin
            product <= product + {pp[31:0], 32'h0};
            phase   <= PH_HL;
          end
          PH_HL: begin
            product <= product + {pp[31:0], 32'h0};
            busy    <= 1'b0;
            phase   <= PH_LL;
          end
          default: phase <= PH_LL;
        endcase
      end
    end
  end

endmodule

// ----- design/mmh_back.sv -----
// back end: mixing sequencer around the shared multiplier, plus result register
module mmh_back (
  input  logic               clk,
  input  logic               rst,
  input  logic [63:0]        seed,
  input  logic               q_valid,
  input  mmh_pkg::op_t       q_op,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [63:0]        out_data,
  output mmh_pkg::bk_stat_t  stat
);
  import mmh_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEED,
    ST_K1,
    ST_K2,
    ST_ACC,
    ST_FIN,
    ST_OUT
  } state_t;

  state_t      state;
  op_t         op_q;
  logic [63:0] acc;
  logic        mul_go;
  logic        mul_go_next;
  logic [63:0] mul_a;
  logic [63:0] mul_prod;
  logic        mul_done;
  logic        mul_busy;

  op_t         disp_op;
  logic [63:0] disp_acc;
  logic [63:0] d_acc;
  logic [63:0] d_a;
  state_t      d_state;
  logic        out_free;
  logic        emit;
  logic [63:0] fin_h;

  mmh_mul u_mul (
    .clk     (clk),
    .rst     (rst),
    .start   (mul_go),
    .operand (mul_a),
    .product (mul_prod),
    .done    (mul_done),
    .busy    (mul_busy)
  );

  assign pop      = (state == ST_IDLE) && q_valid;
  assign out_free = !out_valid || out_ready;
  assign fin_h    = xorshift(mul_prod);
  assign emit     = ((state == ST_FIN) && mul_done && out_free) ||
                    ((state == ST_OUT) && out_free);

  // next multiply starts on a new request or when a chained step finishes
  assign mul_go_next = ((state == ST_IDLE) && q_valid) ||
                       (mul_done && ((state == ST_SEED) || (state == ST_K1) ||
                                     (state == ST_K2) ||
                                     ((state == ST_ACC) && op_q.last)));

  assign stat.busy     = (state != ST_IDLE);
  assign stat.emit     = emit;
  assign stat.mul_busy = mul_busy;

  // start of the mixing work for an operation, from the seeded or carried accumulator
  always_comb begin
    disp_op  = (state == ST_IDLE) ? q_op : op_q;
    disp_acc = (state == ST_SEED) ? (seed ^ mul_prod) : acc;
    unique case (disp_op.kind)
      OP_FULL: begin
        d_acc   = disp_acc;
        d_a     = disp_op.data;
        d_state = ST_K1;
      end
      OP_TAIL: begin
        d_acc   = disp_acc ^ disp_op.data;
        d_a     = d_acc;
        d_state = ST_ACC;
      end
      default: begin
        d_acc   = disp_acc;
        d_a     = xorshift(disp_acc);
        d_state = ST_FIN;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      acc       <= '0;
      mul_go    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      mul_go    <= mul_go_next;
      out_valid <= emit || (out_valid && !out_ready);
      unique case (state)
        ST_IDLE: begin
          if (q_valid) begin
            op_q <= q_op;
            if (q_op.first) begin
              mul_a <= {32'h0, q_op.length};
              state <= ST_SEED;
            end else begin
              mul_a <= d_a;
              acc   <= d_acc;
              state <= d_state;
            end
          end
        end
        ST_SEED: begin
          if (mul_done) begin
            mul_a <= d_a;
            acc   <= d_acc;
            state <= d_state;
          end
        end
        ST_K1: begin
          if (mul_done) begin
            mul_a <= xorshift(mul_prod);
            state <= ST_K2;
          end
        end
        ST_K2: begin
          if (mul_done) begin
            mul_a <= acc ^ mul_prod;
            state <= ST_ACC;
          end
        end
        ST_ACC: begin
          if (mul_done) begin
            acc <= mul_prod;
            if (op_q.last) begin
              mul_a <= xorshift(mul_prod);
              state <= ST_FIN;
            end else begin
              state <= ST_IDLE;
            end
          end
        end
        ST_FIN: begin
          if (mul_done) begin
            acc <= fin_h;
            if (emit) begin
              out_data <= fin_h;
              state    <= ST_IDLE;
            end else begin
              state <= ST_OUT;
            end
          end
        end
        ST_OUT: begin
          if (emit) begin
            out_data <= acc;
            state    <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

// ----- design/murmur64_stream_hash_core.sv -----
// top level of the streaming murmur64a hash core
//
// usage
//   s_axis carries message requests: 64-bit little-endian words, byte count,
//   a first flag in tuser and tlast on the final word of a message. the word
//   flagged first also carries the message length, which seeds the hash as
//   seed xor (length * m). m_axis returns one 64-bit hash per message, after
//   the request that carries tlast. seed is loaded through cfg_wr_en and
//   cfg_wr_data while no message is in flight.
// mixing
//   every 64-bit multiply runs on one shared 32x32 multiplier over three
//   partial products. a full word needs three multiplies, a first request
//   adds one for the seed and a last request one more for the finaliser;
//   a tail-only last word needs one mixing multiply instead of three.
//   a two-entry request queue lets s_axis take requests while the back end
//   is still mixing, so input stalls only when that queue is full.
// reset and stall
//   rst (synchronous) clears the accumulator, the seed, the queue and the result
//   valid flag, not the result data. if m_axis_tready stays low the hash waits
//   in the result register and the back end holds the next hash until it is free.
module murmur64_stream_hash_core (
  input  logic        clk,
  input  logic        rst,
  // request channel
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // from bit 0: data_word[63:0], word_bytes[67:64], message_length[99:68], zero pad
  input  logic [mmh_pkg::TDATA_W-1:0] s_axis_tdata,
  // from bit 0: first
  input  logic        s_axis_tuser,
  input  logic        s_axis_tlast,
  // result channel
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // from bit 0: hash_value[63:0]
  output logic [63:0] m_axis_tdata,
  // seed register write
  input  logic        cfg_wr_en,
  input  logic [63:0] cfg_wr_data
);
  import mmh_pkg::*;

  `include "murmur64_stream_hash_core_defines.svh"

  logic [63:0] seed;
  logic        push;
  op_t         push_op;
  logic        q_full;
  logic        q_valid;
  op_t         q_op;
  logic        q_pop;
  bk_stat_t    bk_stat;

  // seed register; user must write it only while the core is idle; not enforced
  always_ff @(posedge clk) begin
    if (rst) begin
      seed <= '0;
    end else if (cfg_wr_en) begin
      seed <= cfg_wr_data;
    end
  end

  mmh_front u_front (
    .in_valid       (s_axis_tvalid),
    .in_ready       (s_axis_tready),
    .data_word      (s_axis_tdata[63:0]),
    .word_bytes     (s_axis_tdata[67:64]),
    .first          (s_axis_tuser),
    .last           (s_axis_tlast),
    .message_length (s_axis_tdata[99:68]),
    .push           (push),
    .push_op        (push_op),
    .q_full         (q_full)
  );

  mmh_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .push_op (push_op),
    .full    (q_full),
    .q_valid (q_valid),
    .q_op    (q_op),
    .pop     (q_pop)
  );

  mmh_back u_back (
    .clk       (clk),
    .rst       (rst),
    .seed      (seed),
    .q_valid   (q_valid),
    .q_op      (q_op),
    .pop       (q_pop),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (m_axis_tdata),
    .stat      (bk_stat)
  );

  // an accepted request is waiting in the queue on the next cycle
  `MMH_ASSERT_NEXT(a_push_fills_queue, s_axis_tvalid && s_axis_tready, q_valid)
  // the back end only takes a new request with the multiplier free
  `MMH_ASSERT_NOW(a_pop_mul_idle, q_pop, !bk_stat.mul_busy)
  // a finished hash shows up on the result channel next cycle
  `MMH_ASSERT_NEXT(a_emit_shows, bk_stat.emit, m_axis_tvalid)
  // a new result only ever comes from the finaliser
  `MMH_ASSERT_NOW(a_result_source, $rose(m_axis_tvalid), $past(bk_stat.emit))

endmodule

// ----- dv/testbench.sv -----
// self-checking testbench for the streaming murmur64a hash core
`timescale 1ns / 100ps

class hash_scoreboard;
  localparam logic [63:0] MIX_MUL   = 64'hc6a4a7935bd1e995;
  localparam int          MIX_SHIFT = 47;

  logic [63:0] seed_reg;
  logic [63:0] running_hash;
  logic [63:0] expected_hashes[$];
  int          hashes_checked;
  int          mismatches;

  function new();
    seed_reg       = '0;
    running_hash   = '0;
    hashes_checked = 0;
    mismatches     = 0;
  endfunction

  function void flag(string msg);
    mismatches++;
    if (mismatches <= 10) $display("%s", msg);
  endfunction

  // multiply, fold the top bits down, multiply again
  function logic [63:0] scramble_key(logic [63:0] k);
    logic [63:0] t;
    t = k * MIX_MUL;
    t = t ^ (t >> MIX_SHIFT);
    return t * MIX_MUL;
  endfunction

  // fold one accepted request into the running hash
  function void note_request(logic [63:0] word, logic [3:0] nbytes, bit first, bit last,
                             logic [31:0] msg_len);
    int          nb;
    logic [63:0] h;
    nb = (nbytes > 4'd8) ? 8 : int'(nbytes);
    if (first) running_hash = seed_reg ^ ({32'b0, msg_len} * MIX_MUL);
    if (!last) begin
      running_hash = (running_hash ^ scramble_key(word)) * MIX_MUL;
      return;
    end
    if (nb == 8) begin
      running_hash = (running_hash ^ scramble_key(word)) * MIX_MUL;
    end else if (nb != 0) begin
      running_hash = (running_hash ^ (word & ({64{1'b1}} >> (64 - 8 * nb)))) * MIX_MUL;
    end
    h = running_hash;
    h = h ^ (h >> MIX_SHIFT);
    h = h * MIX_MUL;
    h = h ^ (h >> MIX_SHIFT);
    running_hash = h;
    expected_hashes = {expected_hashes, h};
  endfunction

  function void check_hash(logic [63:0] actual);
    logic [63:0] want;
    if (expected_hashes.size() == 0) begin
      flag($sformatf("hash mismatch: none expected, got %h", actual));
      return;
    end
    want = expected_hashes[0];
    expected_hashes.delete(0);
    hashes_checked++;
    if (actual !== want) flag($sformatf("hash mismatch: expected %h, got %h", want, actual));
  endfunction

  function int pending();
    return expected_hashes.size();
  endfunction

  function void finish();
    if (expected_hashes.size() != 0)
      flag($sformatf("hash mismatch: %0d hashes never arrived", expected_hashes.size()));
    mismatches += (expected_hashes.size() > 1) ? expected_hashes.size() - 1 : 0;
  endfunction
endclass

module testbench;

  // cycles with no handshake on either side before the run is abandoned
  localparam int WATCHDOG_LIMIT = 3000;
  // back end settling time: two queued requests plus one in the mixer
  localparam int QUIET_CYCLES   = 100;
  // long receiver hold-off used to back the core up
  localparam int HOLD_CYCLES    = 600;
  localparam int PHASE_ITEMS    = 200;

  logic                         clk           = 1'b0;
  logic                         rst           = 1'b1;
  logic                         s_axis_tvalid = 1'b0;
  logic                         s_axis_tready;
  // from bit 0: data_word[63:0], word_bytes[67:64], message_length[99:68], zero pad
  logic [mmh_pkg::TDATA_W-1:0]  s_axis_tdata  = '0;
  // from bit 0: first
  logic                         s_axis_tuser  = 1'b0;
  logic                         s_axis_tlast  = 1'b0;
  logic                         m_axis_tvalid;
  logic                         m_axis_tready = 1'b0;
  // from bit 0: hash_value[63:0]
  logic [63:0]                  m_axis_tdata;
  logic                         cfg_wr_en     = 1'b0;
  logic [63:0]                  cfg_wr_data   = '0;

  hash_scoreboard sb;

  // idling mix of the current phase, in percent
  int idle_pct  = 0;
  int stall_pct = 0;

  // hold-off hand-over: stimulus bumps the token, receiver counts the cycles
  int hold_token = 0;
  int hold_seen  = 0;
  int hold_left  = 0;
  int idle_cycles = 0;

  int n_requests = 0;
  int n_messages = 0;
  int n_seeds    = 0;

  always #4 clk = ~clk;

  murmur64_stream_hash_core u_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data)
  );

  // result side: check every accepted hash, then pick next cycle's ready
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) sb.check_hash(m_axis_tdata);
      if (hold_token != hold_seen) begin
        hold_seen = hold_token;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else if ($urandom_range(99) < stall_pct) begin
        // stall stretches of varying length so they land on every phase of the work
        hold_left = $urandom_range(0, 20);
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // watchdog: counts cycles with no handshake anywhere
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
      $display("testbench: FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic logic [63:0] rand_word();
    return {$urandom, $urandom};
  endfunction

  // offer one request, with a random gap ahead of it, and wait for acceptance
  task automatic send_req(input logic [63:0] word, input logic [3:0] nb, input bit first,
                          input bit last, input logic [31:0] msg_len);
    int gap;
    gap = ($urandom_range(99) < idle_pct) ? $urandom_range(1, 40) : 0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tdata  <= {4'b0, msg_len, nb, word};
    s_axis_tuser  <= first;
    s_axis_tlast  <= last;
    s_axis_tvalid <= 1'b1;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    sb.note_request(word, nb, first, last, msg_len);
    n_requests++;
    if (last) n_messages++;
  endtask

  // stop offering and wait for every outstanding hash
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // seed is only loaded once the core has gone quiet
  task automatic write_seed(input logic [63:0] value);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    sb.seed_reg = value;
    n_seeds++;
  endtask

  // one random message: mostly well framed, some without a first flag, some noise
  task automatic send_message(output int sent);
    int          roll;
    int          n_words;
    int          tail_nb;
    bit          with_first;
    logic [31:0] msg_len;
    roll = $urandom_range(99);
    if (roll < 6) begin
      send_req(rand_word(), 4'($urandom_range(15)), 1'($urandom_range(1)),
               1'($urandom_range(1)), $urandom);
      sent = 1;
      return;
    end
    with_first = (roll >= 12);
    n_words    = ($urandom_range(9) == 0) ? $urandom_range(4, 12) : $urandom_range(0, 3);
    tail_nb    = ($urandom_range(9) == 0) ? $urandom_range(9, 15) : $urandom_range(0, 8);
    msg_len    = 32'(n_words * 8 + ((tail_nb > 8) ? 8 : tail_nb));
    if ($urandom_range(9) == 0) msg_len = $urandom;
    for (int i = 0; i < n_words; i++) begin
      // byte count on a middle word is ignored, so any value goes
      send_req(rand_word(), 4'($urandom_range(15)), with_first && i == 0, 1'b0,
               (i == 0) ? msg_len : $urandom);
    end
    send_req(rand_word(), 4'(tail_nb), with_first && n_words == 0, 1'b1,
             (n_words == 0) ? msg_len : $urandom);
    sent = n_words + 1;
  endtask

  initial begin
    logic [63:0] phase_seed[4];
    int          phase_idle[4];
    int          phase_stall[4];
    int          sent;
    int          done;
    bit          pressed;

    sb = new();
    phase_seed  = '{64'h0, {64{1'b1}}, rand_word(), rand_word() | 64'h8000_0000_0000_0001};
    phase_idle  = '{0, 65, 0, 27};
    phase_stall = '{0, 0, 65, 27};

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // directed: words with no first flag straight after reset mix into a zero accumulator
    write_seed(phase_seed[0]);
    send_req(64'h0123_4567_89ab_cdef, 4'd8, 1'b0, 1'b0, 32'h0);
    send_req({64{1'b1}}, 4'd3, 1'b0, 1'b1, 32'h0);
    // unframed words after a finished message continue from its hash
    send_req({64{1'b1}}, 4'd15, 1'b0, 1'b0, 32'hffff_ffff);
    send_req(64'h0, 4'd0, 1'b0, 1'b1, 32'h0);
    // empty message, single full word
    send_req(rand_word(), 4'd0, 1'b1, 1'b1, 32'd0);
    send_req({64{1'b1}}, 4'd8, 1'b1, 1'b1, 32'd8);
    // tail-only messages of every short length, upper bytes must be masked
    for (int nb = 1; nb < 8; nb++) send_req({64{1'b1}}, 4'(nb), 1'b1, 1'b1, 32'(nb));
    // byte count above eight saturates, longest length field
    send_req(64'h8000_0000_0000_0000, 4'd15, 1'b1, 1'b1, 32'hffff_ffff);
    // multi-word message with odd byte counts on middle words
    send_req(64'h0, 4'd8, 1'b1, 1'b0, 32'hffff_ffff);
    send_req({64{1'b1}}, 4'd0, 1'b0, 1'b0, 32'h0);
    send_req(64'ha5a5_a5a5_a5a5_a5a5, 4'd15, 1'b0, 1'b0, 32'h5555_5555);
    send_req(64'h5a5a_5a5a_5a5a_5a5a, 4'd5, 1'b0, 1'b1, 32'haaaa_aaaa);
    // a second first flag restarts the message
    send_req(rand_word(), 4'd8, 1'b1, 1'b0, 32'd16);
    send_req(rand_word(), 4'd9, 1'b1, 1'b1, 32'd8);

    for (int ph = 0; ph < 4; ph++) begin
      idle_pct  = phase_idle[ph];
      stall_pct = phase_stall[ph];
      if (ph > 0) begin
        wait_drained();
        repeat (QUIET_CYCLES) @(posedge clk);
        write_seed(phase_seed[ph]);
      end
      done    = 0;
      pressed = 1'b0;
      while (done < PHASE_ITEMS) begin
        if (!pressed && done >= PHASE_ITEMS / 2) begin
          pressed = 1'b1;
          // let results drain fully, then, in the first and last phases, back the core up behind a stalled receiver
          wait_drained();
          if (ph == 0 || ph == 3) hold_token <= hold_token + 1;
        end
        send_message(sent);
        done += sent;
      end
    end

    wait_drained();
    repeat (QUIET_CYCLES) @(posedge clk);
    sb.finish();

    $display("summary: %0d requests, %0d messages, %0d hashes checked under %0d seeds",
             n_requests, n_messages, sb.hashes_checked, n_seeds);
    $display("summary: empty, tail-only, saturated and unframed messages; four idle/stall mixes");
    if (sb.mismatches == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("%0d mismatches", sb.mismatches);
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule
